// ===== hdl/lfps_pkg.sv =====
// Shared types, widths and register codes of the line follower steering unit.
package lfps_pkg;

    localparam int READ_W = 16;
    localparam int GAIN_W = 16;
    localparam int DUTY_W = 8;
    localparam int ERR_W = 17;
    localparam int DIFF_W = 18;
    localparam int TERM_LIMIT_EXP = 40;
    localparam int ITERM_W = TERM_LIMIT_EXP + 2;
    localparam int TOTAL_W = TERM_LIMIT_EXP + 4;
    localparam int Q_W = 10;
    localparam int Q_LIMIT = 255;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_STRAIGHT   = 2'd0,
        ACT_SPIN_LEFT  = 2'd1,
        ACT_SPIN_RIGHT = 2'd2,
        ACT_PID        = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_LEFT   = 2'd1,
        MODE_RIGHT  = 2'd2
    } mode_t;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_BLACK_THRESHOLD = 3'd0;
    localparam reg_index_t REG_BASE_SPEED      = 3'd1;
    localparam reg_index_t REG_TURN_SPEED      = 3'd2;
    localparam reg_index_t REG_GAIN_P          = 3'd3;
    localparam reg_index_t REG_GAIN_I          = 3'd4;
    localparam reg_index_t REG_GAIN_D          = 3'd5;

    localparam logic [READ_W-1:0] RESET_BLACK_THRESHOLD = 16'd800;
    localparam logic [DUTY_W-1:0] RESET_BASE_SPEED      = 8'd180;
    localparam logic [DUTY_W-1:0] RESET_TURN_SPEED      = 8'd160;
    localparam logic [GAIN_W-1:0] RESET_GAIN_P          = 16'd384;
    localparam logic [GAIN_W-1:0] RESET_GAIN_I          = 16'd0;
    localparam logic [GAIN_W-1:0] RESET_GAIN_D          = 16'd128;

endpackage

// ===== hdl/line_follower_pid_steering_unit.sv =====
// Top level of the line follower PID steering unit.
// Each request carries one sample of four clear-channel light readings and yields
// one motor command. The unit is a six-register pipeline that takes a new request
// in every cycle when the output side is not stalled. Readings below
// black_threshold count as black. The steering mode and the PID error history
// are updated in the second stage, so consecutive samples see each other's
// state with no gaps. The three gain products are formed in the third stage,
// summed in the fourth, scaled and limited in the fifth, and mixed with
// base_speed in the output register. Configuration must be written through the
// APB port only while no request is in flight; the unit does not enforce this.
module line_follower_pid_steering_unit #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int ACCUM_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lfps_pkg::ADDR_W-1:0]        paddr,
    input  logic [lfps_pkg::DATA_W-1:0]        pwdata,
    output logic [lfps_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lfps_pkg::READ_W-1:0]        far_left_clear,
    input  logic [lfps_pkg::READ_W-1:0]        left_clear,
    input  logic [lfps_pkg::READ_W-1:0]        right_clear,
    input  logic [lfps_pkg::READ_W-1:0]        far_right_clear,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lfps_pkg::DUTY_W-1:0]        motor_a_forward,
    output logic [lfps_pkg::DUTY_W-1:0]        motor_a_reverse,
    output logic [lfps_pkg::DUTY_W-1:0]        motor_b_forward,
    output logic [lfps_pkg::DUTY_W-1:0]        motor_b_reverse,
    output logic [1:0]                         action
);

    localparam int SUM_W = ACCUM_BITS + 1;
    localparam int PP_W = lfps_pkg::GAIN_W + 1 + lfps_pkg::ERR_W;
    localparam int PD_W = lfps_pkg::GAIN_W + 1 + lfps_pkg::DIFF_W;
    localparam int PI_W = lfps_pkg::GAIN_W + 1 + ACCUM_BITS;
    localparam int IW = (PI_W > lfps_pkg::ITERM_W) ? PI_W : lfps_pkg::ITERM_W;
    localparam int TW = lfps_pkg::TOTAL_W;
    localparam int QW = lfps_pkg::Q_W;
    localparam int VW = lfps_pkg::DUTY_W + 3;

    localparam logic signed [IW-1:0] TERM_MAX = IW'(64'sd1 <<< lfps_pkg::TERM_LIMIT_EXP);
    localparam logic signed [IW-1:0] TERM_MIN = -TERM_MAX;
    localparam logic signed [TW-1:0] ROUND_BIAS = TW'((64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1);
    localparam logic signed [TW-1:0] Q_MAX_T = TW'(lfps_pkg::Q_LIMIT);
    localparam logic signed [TW-1:0] Q_MIN_T = -Q_MAX_T;
    localparam logic signed [ACCUM_BITS-1:0] SUM_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
    localparam logic signed [ACCUM_BITS-1:0] SUM_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};
    localparam logic signed [VW-1:0] DUTY_MAX = VW'((1 << lfps_pkg::DUTY_W) - 1);

    // Configuration registers.
    logic [lfps_pkg::READ_W-1:0] black_threshold_reg;
    logic [lfps_pkg::DUTY_W-1:0] base_speed_reg;
    logic [lfps_pkg::DUTY_W-1:0] turn_speed_reg;
    logic [lfps_pkg::GAIN_W-1:0] gain_p_reg;
    logic [lfps_pkg::GAIN_W-1:0] gain_i_reg;
    logic [lfps_pkg::GAIN_W-1:0] gain_d_reg;

    logic                   cfg_write;
    lfps_pkg::reg_index_t   cfg_index;

    // Pipeline registers.
    logic                              s1_valid_reg;
    logic [lfps_pkg::READ_W-1:0]       s1_far_left_reg;
    logic [lfps_pkg::READ_W-1:0]       s1_left_reg;
    logic [lfps_pkg::READ_W-1:0]       s1_right_reg;
    logic [lfps_pkg::READ_W-1:0]       s1_far_right_reg;

    logic                              s2_valid_reg;
    lfps_pkg::action_t                 s2_action_reg;
    logic signed [lfps_pkg::ERR_W-1:0] s2_err_reg;
    logic signed [ACCUM_BITS-1:0]      s2_sum_reg;
    logic signed [lfps_pkg::DIFF_W-1:0] s2_diff_reg;

    logic                              s3_valid_reg;
    lfps_pkg::action_t                 s3_action_reg;
    logic signed [PP_W-1:0]            s3_prod_p_reg;
    logic signed [PI_W-1:0]            s3_prod_i_reg;
    logic signed [PD_W-1:0]            s3_prod_d_reg;

    logic                              s4_valid_reg;
    lfps_pkg::action_t                 s4_action_reg;
    logic signed [TW-1:0]              s4_total_reg;

    logic                              s5_valid_reg;
    lfps_pkg::action_t                 s5_action_reg;
    logic signed [QW-1:0]              s5_q_reg;

    logic                              out_valid_reg;
    lfps_pkg::action_t                 out_action_reg;
    logic [lfps_pkg::DUTY_W-1:0]       out_a_fwd_reg;
    logic [lfps_pkg::DUTY_W-1:0]       out_a_rev_reg;
    logic [lfps_pkg::DUTY_W-1:0]       out_b_fwd_reg;
    logic [lfps_pkg::DUTY_W-1:0]       out_b_rev_reg;

    // Steering state.
    lfps_pkg::mode_t                   mode_reg;
    lfps_pkg::mode_t                   mode_next;
    logic signed [lfps_pkg::ERR_W-1:0] prev_err_reg;
    logic signed [ACCUM_BITS-1:0]      err_sum_reg;

    logic out_free, s5_free, s4_free, s3_free, s2_free, s1_free;

    logic blk_fl, blk_l, blk_r, blk_fr;
    lfps_pkg::action_t                 s2_action_next;
    logic                              pid_update;
    logic signed [lfps_pkg::ERR_W-1:0] err_next;
    logic signed [SUM_W-1:0]           sum_wide;
    logic signed [ACCUM_BITS-1:0]      sum_next;
    logic signed [lfps_pkg::DIFF_W-1:0] diff_next;

    logic signed [IW-1:0]              iterm_ext;
    logic signed [lfps_pkg::ITERM_W-1:0] iterm;
    logic signed [TW-1:0]              total_next;

    logic signed [TW-1:0]              total_biased;
    logic signed [TW-1:0]              total_scaled;
    logic signed [QW-1:0]              q_next;

    logic signed [VW-1:0]              va_wide;
    logic signed [VW-1:0]              vb_wide;
    logic [lfps_pkg::DUTY_W-1:0]       va;
    logic [lfps_pkg::DUTY_W-1:0]       vb;
    logic [lfps_pkg::DUTY_W-1:0]       a_fwd_next, a_rev_next, b_fwd_next, b_rev_next;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[lfps_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_threshold_reg <= lfps_pkg::RESET_BLACK_THRESHOLD;
            base_speed_reg      <= lfps_pkg::RESET_BASE_SPEED;
            turn_speed_reg      <= lfps_pkg::RESET_TURN_SPEED;
            gain_p_reg          <= lfps_pkg::RESET_GAIN_P;
            gain_i_reg          <= lfps_pkg::RESET_GAIN_I;
            gain_d_reg          <= lfps_pkg::RESET_GAIN_D;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lfps_pkg::REG_BLACK_THRESHOLD: black_threshold_reg <= pwdata[lfps_pkg::READ_W-1:0];
                lfps_pkg::REG_BASE_SPEED:      base_speed_reg <= pwdata[lfps_pkg::DUTY_W-1:0];
                lfps_pkg::REG_TURN_SPEED:      turn_speed_reg <= pwdata[lfps_pkg::DUTY_W-1:0];
                lfps_pkg::REG_GAIN_P:          gain_p_reg <= pwdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_GAIN_I:          gain_i_reg <= pwdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_GAIN_D:          gain_d_reg <= pwdata[lfps_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            lfps_pkg::REG_BLACK_THRESHOLD: prdata = lfps_pkg::DATA_W'(black_threshold_reg);
            lfps_pkg::REG_BASE_SPEED:      prdata = lfps_pkg::DATA_W'(base_speed_reg);
            lfps_pkg::REG_TURN_SPEED:      prdata = lfps_pkg::DATA_W'(turn_speed_reg);
            lfps_pkg::REG_GAIN_P:          prdata = lfps_pkg::DATA_W'(gain_p_reg);
            lfps_pkg::REG_GAIN_I:          prdata = lfps_pkg::DATA_W'(gain_i_reg);
            lfps_pkg::REG_GAIN_D:          prdata = lfps_pkg::DATA_W'(gain_d_reg);
            default:                       prdata = '0;
        endcase
    end

    // A stage takes a new request when it is empty or its content moves on.
    assign out_free = !out_valid_reg || out_ready;
    assign s5_free  = !s5_valid_reg || out_free;
    assign s4_free  = !s4_valid_reg || s5_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    // Mode decision and error history.
    always_comb
    begin
        blk_fl = s1_far_left_reg < black_threshold_reg;
        blk_l  = s1_left_reg < black_threshold_reg;
        blk_r  = s1_right_reg < black_threshold_reg;
        blk_fr = s1_far_right_reg < black_threshold_reg;

        err_next  = $signed({1'b0, s1_left_reg}) - $signed({1'b0, s1_right_reg});
        sum_wide  = SUM_W'(err_sum_reg) + SUM_W'(err_next);
        if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2])
        begin
            sum_next = sum_wide[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[ACCUM_BITS-1:0];
        end
        diff_next = lfps_pkg::DIFF_W'(err_next) - lfps_pkg::DIFF_W'(prev_err_reg);

        pid_update     = 1'b0;
        mode_next      = lfps_pkg::MODE_NORMAL;
        s2_action_next = lfps_pkg::ACT_PID;
        case (mode_reg)
            lfps_pkg::MODE_LEFT:
            begin
                s2_action_next = lfps_pkg::ACT_SPIN_LEFT;
                mode_next = blk_l ? lfps_pkg::MODE_NORMAL : lfps_pkg::MODE_LEFT;
            end
            lfps_pkg::MODE_RIGHT:
            begin
                s2_action_next = lfps_pkg::ACT_SPIN_RIGHT;
                mode_next = blk_r ? lfps_pkg::MODE_NORMAL : lfps_pkg::MODE_RIGHT;
            end
            default:
            begin
                if (blk_fl && blk_l && blk_r && blk_fr)
                begin
                    s2_action_next = lfps_pkg::ACT_STRAIGHT;
                end
                else if (blk_fl)
                begin
                    s2_action_next = lfps_pkg::ACT_SPIN_LEFT;
                    mode_next = lfps_pkg::MODE_LEFT;
                end
                else if (blk_fr)
                begin
                    s2_action_next = lfps_pkg::ACT_SPIN_RIGHT;
                    mode_next = lfps_pkg::MODE_RIGHT;
                end
                else
                begin
                    pid_update = 1'b1;
                end
            end
        endcase
    end

    // The integral term is limited before the sum; the clamped output is unchanged.
    always_comb
    begin
        iterm_ext = IW'(s3_prod_i_reg);
        if (iterm_ext > TERM_MAX)
        begin
            iterm = lfps_pkg::ITERM_W'(TERM_MAX);
        end
        else if (iterm_ext < TERM_MIN)
        begin
            iterm = lfps_pkg::ITERM_W'(TERM_MIN);
        end
        else
        begin
            iterm = iterm_ext[lfps_pkg::ITERM_W-1:0];
        end
        total_next = TW'(s3_prod_p_reg) + TW'(s3_prod_d_reg) + TW'(iterm);
    end

    // Division by the gain scale truncates toward zero; the quotient is then limited to -255..255.
    always_comb
    begin
        total_biased = s4_total_reg + (s4_total_reg[TW-1] ? ROUND_BIAS : '0);
        total_scaled = total_biased >>> GAIN_FRAC_BITS;
        if (total_scaled > Q_MAX_T)
        begin
            q_next = QW'(Q_MAX_T);
        end
        else if (total_scaled < Q_MIN_T)
        begin
            q_next = QW'(Q_MIN_T);
        end
        else
        begin
            q_next = total_scaled[QW-1:0];
        end
    end

    always_comb
    begin
        va_wide = $signed({3'b000, base_speed_reg}) + VW'(s5_q_reg);
        vb_wide = $signed({3'b000, base_speed_reg}) - VW'(s5_q_reg);
        if (va_wide[VW-1])
        begin
            va = '0;
        end
        else if (va_wide > DUTY_MAX)
        begin
            va = '1;
        end
        else
        begin
            va = va_wide[lfps_pkg::DUTY_W-1:0];
        end
        if (vb_wide[VW-1])
        begin
            vb = '0;
        end
        else if (vb_wide > DUTY_MAX)
        begin
            vb = '1;
        end
        else
        begin
            vb = vb_wide[lfps_pkg::DUTY_W-1:0];
        end

        case (s5_action_reg)
            lfps_pkg::ACT_STRAIGHT:
            begin
                a_fwd_next = base_speed_reg;
                a_rev_next = '0;
                b_fwd_next = base_speed_reg;
                b_rev_next = '0;
            end
            lfps_pkg::ACT_SPIN_LEFT:
            begin
                a_fwd_next = '0;
                a_rev_next = turn_speed_reg;
                b_fwd_next = turn_speed_reg;
                b_rev_next = '0;
            end
            lfps_pkg::ACT_SPIN_RIGHT:
            begin
                a_fwd_next = turn_speed_reg;
                a_rev_next = '0;
                b_fwd_next = '0;
                b_rev_next = turn_speed_reg;
            end
            default:
            begin
                a_fwd_next = va;
                a_rev_next = '0;
                b_fwd_next = vb;
                b_rev_next = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= lfps_pkg::MODE_NORMAL;
            prev_err_reg  <= '0;
            err_sum_reg   <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_free)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s5_valid_reg;
            end
            if (s1_valid_reg && s2_free)
            begin
                mode_reg <= mode_next;
                if (pid_update)
                begin
                    prev_err_reg <= err_next;
                    err_sum_reg  <= sum_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            s1_far_left_reg  <= far_left_clear;
            s1_left_reg      <= left_clear;
            s1_right_reg     <= right_clear;
            s1_far_right_reg <= far_right_clear;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_action_reg <= s2_action_next;
            s2_err_reg    <= err_next;
            s2_sum_reg    <= sum_next;
            s2_diff_reg   <= diff_next;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_action_reg <= s2_action_reg;
            s3_prod_p_reg <= PP_W'($signed({1'b0, gain_p_reg})) * PP_W'(s2_err_reg);
            s3_prod_i_reg <= PI_W'($signed({1'b0, gain_i_reg})) * PI_W'(s2_sum_reg);
            s3_prod_d_reg <= PD_W'($signed({1'b0, gain_d_reg})) * PD_W'(s2_diff_reg);
        end
        if (s4_free && s3_valid_reg)
        begin
            s4_action_reg <= s3_action_reg;
            s4_total_reg  <= total_next;
        end
        if (s5_free && s4_valid_reg)
        begin
            s5_action_reg <= s4_action_reg;
            s5_q_reg      <= q_next;
        end
        if (out_free && s5_valid_reg)
        begin
            out_action_reg <= s5_action_reg;
            out_a_fwd_reg  <= a_fwd_next;
            out_a_rev_reg  <= a_rev_next;
            out_b_fwd_reg  <= b_fwd_next;
            out_b_rev_reg  <= b_rev_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign motor_a_forward = out_a_fwd_reg;
    assign motor_a_reverse = out_a_rev_reg;
    assign motor_b_forward = out_b_fwd_reg;
    assign motor_b_reverse = out_b_rev_reg;
    assign action          = out_action_reg;

endmodule

// ===== hdl/lfps_checker.sv =====
// Port-level checks of the line follower steering unit and their binding.
module lfps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lfps_pkg::DUTY_W-1:0]   motor_a_forward,
    input logic [lfps_pkg::DUTY_W-1:0]   motor_a_reverse,
    input logic [lfps_pkg::DUTY_W-1:0]   motor_b_forward,
    input logic [lfps_pkg::DUTY_W-1:0]   motor_b_reverse,
    input logic [1:0]                    action
);

    // A stalled result keeps its duties and action.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
            && $stable(motor_a_forward) && $stable(motor_a_reverse)
            && $stable(motor_b_forward) && $stable(motor_b_reverse))
    else $error("stalled result changed");

    // Straight and PID results never drive a motor in reverse.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == lfps_pkg::ACT_PID || action == lfps_pkg::ACT_STRAIGHT)
            |-> motor_a_reverse == '0 && motor_b_reverse == '0)
    else $error("reverse duty on a forward result");

    // Driving straight uses the same duty on both motors.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == lfps_pkg::ACT_STRAIGHT |-> motor_a_forward == motor_b_forward)
    else $error("straight result with unequal duties");

    // A spin drives the motors in opposite directions at one duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == lfps_pkg::ACT_SPIN_LEFT
            |-> motor_a_forward == '0 && motor_b_reverse == '0
                && motor_a_reverse == motor_b_forward)
    else $error("malformed left spin");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == lfps_pkg::ACT_SPIN_RIGHT
            |-> motor_a_reverse == '0 && motor_b_forward == '0
                && motor_a_forward == motor_b_reverse)
    else $error("malformed right spin");

endmodule

bind line_follower_pid_steering_unit lfps_checker u_lfps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .motor_a_forward (motor_a_forward),
    .motor_a_reverse (motor_a_reverse),
    .motor_b_forward (motor_b_forward),
    .motor_b_reverse (motor_b_reverse),
    .action          (action)
);
